[rtl/lfia_pkg.sv]
// Shared types and constants for the lowest-free ID allocator.
// Holds table size, key width, operation codes and the item structs.
// No dependencies.
`default_nettype none

package lfia_pkg;

	localparam int ENTRIES   = 16;
	localparam int KEY_WIDTH = 32;

	// Field widths of the request and result items.
	localparam int OP_W    = 3;
	localparam int KEY_F_W = 32;
	localparam int ID_W    = 5;

	localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
	localparam logic [OP_W-1:0] OP_REM_KEY   = 3'd1;
	localparam logic [OP_W-1:0] OP_REM_ID    = 3'd2;
	localparam logic [OP_W-1:0] OP_QUERY_KEY = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY_ID  = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [ID_W-1:0]      id_t;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [KEY_F_W-1:0] key;
		logic [ID_W-1:0]    id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]    result_id;
		logic               ok;
		logic [KEY_F_W-1:0] result_key;
	} rsp_t;

	// Data rippled from cell to cell, lowest slot first.
	typedef struct packed {
		logic free_seen;
		id_t  free_id;
		logic key_hit;
		id_t  key_id;
		logic id_hit;
		key_t id_key;
	} link_t;

endpackage

`default_nettype wire

[rtl/lfia_cell.sv]
// One table slot of the lowest-free ID allocator: valid flag and bound key.
// Compares the request, joins the neighbor chain and updates its slot.
// Depends on lfia_pkg.
`default_nettype none

module lfia_cell (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             go,
	input  wire logic [lfia_pkg::OP_W-1:0]        op,
	input  wire lfia_pkg::key_t                   key,
	input  wire lfia_pkg::id_t                    id,
	input  wire lfia_pkg::id_t                    cell_id,
	input  wire logic                             any_key_hit,
	input  wire lfia_pkg::link_t                  link_in,
	output lfia_pkg::link_t                       link_out
);
	import lfia_pkg::*;

	logic valid_q;
	key_t key_q;
	logic valid_d;
	logic key_hit;
	logic id_hit;
	logic claim;

	assign key_hit = valid_q && (key_q == key);
	assign id_hit  = valid_q && (id == cell_id);
	// First free slot takes the key, unless the key is bound somewhere.
	assign claim   = !link_in.free_seen && !valid_q && !any_key_hit;

	always_comb begin
		link_out.free_seen = link_in.free_seen | ~valid_q;
		link_out.free_id   = (!link_in.free_seen && !valid_q) ? cell_id : link_in.free_id;
		link_out.key_hit   = link_in.key_hit | key_hit;
		link_out.key_id    = link_in.key_id | (key_hit ? cell_id : '0);
		link_out.id_hit    = link_in.id_hit | id_hit;
		link_out.id_key    = link_in.id_key | (id_hit ? key_q : '0);
	end

	always_comb begin
		valid_d = valid_q;
		unique case (op)
			OP_ALLOC:   if (claim) valid_d = 1'b1;
			OP_REM_KEY: if (key_hit) valid_d = 1'b0;
			OP_REM_ID:  if (id_hit) valid_d = 1'b0;
			OP_CLEAR:   valid_d = 1'b0;
			default:    valid_d = valid_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (go) begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && op == OP_ALLOC && claim) begin
			key_q <= key;
		end
	end

endmodule

`default_nettype wire

[rtl/lowest_free_id_allocator.sv]
// The request is registered, then the key compare and the ripple through the
// row of cells feed the registered result and its strobe. A new item is not
// taken while busy is high, i.e. while the previous item is in the compare.
// Reset: table empty, busy low, no strobe. The receiver cannot stall.
// Depends on lfia_pkg and lfia_cell.
`default_nettype none

module lowest_free_id_allocator (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire lfia_pkg::req_t req,
	output logic                busy,
	output logic                done,
	output lfia_pkg::rsp_t      rsp
);
	import lfia_pkg::*;

	logic  valid_s1;
	req_t  req_s1;
	key_t  req_key;
	link_t link [ENTRIES+1];
	link_t last;
	rsp_t  rsp_d;
	rsp_t  rsp_q;
	logic  done_q;

	assign busy    = valid_s1;
	assign req_key = KEY_WIDTH'(req_s1.key);
	assign link[0] = '0;
	assign last    = link[ENTRIES];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lfia_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.go          (valid_s1),
			.op          (req_s1.operation),
			.key         (req_key),
			.id          (req_s1.id),
			.cell_id     (ID_W'(i + 1)),
			.any_key_hit (last.key_hit),
			.link_in     (link[i]),
			.link_out    (link[i+1])
		);
	end

	always_comb begin
		rsp_d = '0;
		unique case (req_s1.operation)
			OP_ALLOC: begin
				if (last.key_hit) begin
					rsp_d.result_id = last.key_id;
					rsp_d.ok        = 1'b1;
				end else if (last.free_seen) begin
					rsp_d.result_id = last.free_id;
					rsp_d.ok        = 1'b1;
				end
			end
			OP_REM_KEY, OP_QUERY_KEY: begin
				if (last.key_hit) begin
					rsp_d.result_id = last.key_id;
					rsp_d.ok        = 1'b1;
				end
			end
			OP_REM_ID, OP_QUERY_ID: begin
				if (last.id_hit) begin
					rsp_d.result_id  = req_s1.id;
					rsp_d.ok         = 1'b1;
					rsp_d.result_key = KEY_F_W'(last.id_key);
				end
			end
			OP_CLEAR: rsp_d.ok = 1'b1;
			default:  rsp_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !valid_s1;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !valid_s1) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

[tb/lowest_free_id_checker.sv]
// Response checker for the lowest-free ID allocator: watches the request and
// result channels, keeps its own copy of the ID table and compares each result.
// Depends on lfia_pkg.
`default_nettype none

module lowest_free_id_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           busy,
	input  wire logic           done,
	input  wire lfia_pkg::req_t req,
	input  wire lfia_pkg::rsp_t rsp,
	output int                  errors,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import lfia_pkg::*;

	logic bound [ENTRIES];
	key_t bound_key [ENTRIES];
	rsp_t awaited_rsp [$];
	rsp_t want;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int slot_of_key(key_t k);
		for (int s = 0; s < ENTRIES; s++)
			if (bound[s] && bound_key[s] == k)
				return s;
		return -1;
	endfunction

	// Applies one request to the shadow table and returns the result it should give.
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		key_t k;
		int s;
		int idx;
		o = '0;
		k = key_t'(r.key);
		idx = int'(r.id);
		case (r.operation)
		OP_ALLOC: begin
			s = slot_of_key(k);
			if (s < 0) begin
				// lowest free slot, ENTRIES when the table is full
				s = 0;
				while (s < ENTRIES && bound[s])
					s++;
				if (s < ENTRIES) begin
					bound[s] = 1'b1;
					bound_key[s] = k;
				end
			end
			if (s < ENTRIES) begin
				o.result_id = id_t'(s + 1);
				o.ok = 1'b1;
			end
		end
		OP_REM_KEY, OP_QUERY_KEY: begin
			s = slot_of_key(k);
			if (s >= 0) begin
				if (r.operation == OP_REM_KEY)
					bound[s] = 1'b0;
				o.result_id = id_t'(s + 1);
				o.ok = 1'b1;
			end
		end
		OP_REM_ID, OP_QUERY_ID: begin
			if (idx != 0 && idx <= ENTRIES && bound[idx - 1]) begin
				o.result_key = bound_key[idx - 1];
				if (r.operation == OP_REM_ID)
					bound[idx - 1] = 1'b0;
				o.result_id = r.id;
				o.ok = 1'b1;
			end
		end
		OP_CLEAR: begin
			for (int i = 0; i < ENTRIES; i++)
				bound[i] = 1'b0;
			o.ok = 1'b1;
		end
		default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				bound[i] = 1'b0;
			awaited_rsp.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			// a strobe at this edge always belongs to an earlier item
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch($sformatf("unexpected result: id %0d ok %0b key %08h",
						rsp.result_id, rsp.ok, rsp.result_key));
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.result_id !== want.result_id)
						report_mismatch($sformatf("result_id: got %0d, want %0d",
							rsp.result_id, want.result_id));
					if (rsp.ok !== want.ok)
						report_mismatch($sformatf("ok: got %0b, want %0b", rsp.ok, want.ok));
					if (rsp.result_key !== want.result_key)
						report_mismatch($sformatf("result_key: got %08h, want %08h",
							rsp.result_key, want.result_key));
				end
			end
			if (start && !busy)
				awaited_rsp.push_back(apply_request(req));
			outstanding = awaited_rsp.size();
		end
	end

endmodule

`default_nettype wire

[tb/lowest_free_id_allocator_tb.sv]
// Top of the allocator testbench: clock, reset, directed and random requests,
// stall watchdog and the verdict. Depends on lfia_pkg, lowest_free_id_allocator
// and lowest_free_id_checker.
`default_nettype none

module lowest_free_id_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lfia_pkg::*;

	localparam int N_ITEMS     = 1750;
	localparam int STALL_LIMIT = 1000;
	localparam int POOL        = 20;

	// codes the block ignores
	localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

	logic clk;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;
	int   errors;
	int   outstanding;
	int   stall_cycles = 0;

	logic [KEY_F_W-1:0] key_pool [POOL];

	lowest_free_id_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	lowest_free_id_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.req         (req),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// low first, so the first rising edge comes at 1 ns
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic req_t mk(logic [OP_W-1:0] op, logic [KEY_F_W-1:0] k, logic [ID_W-1:0] i);
		req_t r;
		r.operation = op;
		r.key = k;
		r.id = i;
		return r;
	endfunction

	// holds start until the item is taken
	task automatic send(input req_t r);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		@(posedge clk);
	endtask

	initial begin
		int sent;
		int pick;
		bit calm;
		bit paused;
		logic [OP_W-1:0] op;
		logic [KEY_F_W-1:0] k;
		logic [ID_W-1:0] i;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, fill, full, hits and misses, out-of-range ids
		send(mk(OP_QUERY_KEY, 32'h0, 5'd0));
		send(mk(OP_QUERY_ID, 32'h0, 5'd1));
		for (int n = 0; n < ENTRIES; n++)
			send(mk(OP_ALLOC, (n == 0) ? 32'h0 : (n == 1) ? 32'hFFFF_FFFF : 32'h5A00_0000 + n,
				5'd0));
		send(mk(OP_ALLOC, 32'hDEAD_BEEF, 5'd0));
		send(mk(OP_ALLOC, 32'hFFFF_FFFF, 5'd0));
		send(mk(OP_QUERY_KEY, 32'hFFFF_FFFF, 5'd31));
		send(mk(OP_QUERY_ID, 32'hFFFF_FFFF, ID_W'(ENTRIES)));
		send(mk(OP_QUERY_ID, 32'h0, 5'd0));
		send(mk(OP_QUERY_ID, 32'h0, 5'd31));
		send(mk(OP_REM_ID, 32'h0, ID_W'(ENTRIES + 1)));
		send(mk(OP_REM_ID, 32'h0, ID_W'(ENTRIES)));
		send(mk(OP_REM_ID, 32'h0, ID_W'(ENTRIES)));
		send(mk(OP_ALLOC, 32'h8000_0001, 5'd0));
		send(mk(OP_REM_KEY, 32'h0, 5'd0));
		send(mk(OP_REM_KEY, 32'h0, 5'd0));
		send(mk(OP_ALLOC, 32'h0000_0001, 5'd0));
		send(mk(OP_RSVD_LO, 32'hFFFF_FFFF, 5'd31));
		send(mk(OP_RSVD_HI, 32'h0000_0001, 5'd1));
		send(mk(OP_CLEAR, 32'h0, 5'd0));
		send(mk(OP_QUERY_ID, 32'h0, 5'd2));

		// random: keys mostly from a small pool so hits, removals and a full table occur
		sent = 0;
		paused = 1'b0;
		while (sent < N_ITEMS) begin
			calm = (sent >= 600 && sent < 900);
			if (!calm && $urandom_range(0, 99) < 9) begin
				start <= 1'b0;
				@(posedge clk);
			end else begin
				if (sent % 400 == 0)
					foreach (key_pool[n])
						key_pool[n] = $urandom;
				if (sent == 1100 && !paused) begin
					drain();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 42)
					op = OP_ALLOC;
				else if (pick < 54)
					op = OP_REM_KEY;
				else if (pick < 66)
					op = OP_REM_ID;
				else if (pick < 78)
					op = OP_QUERY_KEY;
				else if (pick < 94)
					op = OP_QUERY_ID;
				else if (pick < 96)
					op = OP_CLEAR;
				else
					op = $urandom_range(0, 1) ? OP_RSVD_HI : OP_RSVD_LO;
				k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL - 1)];
				i = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, 31))
					: ID_W'($urandom_range(1, ENTRIES));
				send(mk(op, k, i));
				if (op != OP_RSVD_LO && op != OP_RSVD_HI)
					sent++;
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
